FILE: rtl/prc_pkg.sv
// Shared constants and types of the polyline rectangle clipper.
package prc_pkg;

  localparam int VERT_W        = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_SPAN_X = 3'd2,
    REG_CLIP_SPAN_Y = 3'd3,
    REG_SHIFT_X     = 3'd4,
    REG_SHIFT_Y     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_t;

  typedef struct packed {
    logic [CFG_W-1:0] left;
    logic [CFG_W-1:0] top;
    logic [CFG_W-1:0] span_x;
    logic [CFG_W-1:0] span_y;
  } clip_cfg_t;

endpackage

FILE: rtl/prc_in_if.sv
// Vertex input channel.
interface prc_in_if;
  import prc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VERT_W-1:0] vert_x;
  logic signed [VERT_W-1:0] vert_y;
  logic                     line_start;

  modport source (output valid, output vert_x, output vert_y, output line_start, input ready);
  modport sink   (input valid, input vert_x, input vert_y, input line_start, output ready);
endinterface

FILE: rtl/prc_out_if.sv
// Clipped point output channel.
interface prc_out_if #(
  parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
);
  import prc_pkg::*;

  localparam int OW = VERT_W + FRAC_BITS + 1;

  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] point_x;
  logic signed [OW-1:0] point_y;
  logic                 segment_last;

  modport source (output valid, output point_x, output point_y, output segment_last,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input segment_last,
                  output ready);
endinterface

FILE: rtl/polyline_rect_clipper.sv
// Polyline rectangle clipper: configuration registers, sequencer and point output buffer.
//
// Vertices arrive on in_ch; a vertex that starts a polyline is only stored as the
// start of the next segment. A segment is taken at intake and then tested against
// each edge in turn. For each edge it crosses, the sequencer finds the distance,
// does two multiplies, and runs a serial divide that yields one quotient bit of x
// and y per cycle. It then hands the segment off once the output buffer is empty.
// in_ch is not ready while a segment is in work. The
// two endpoints of a visible segment leave on out_ch from a two-entry buffer,
// start point first, so the next vertex can be taken while they drain.
module polyline_rect_clipper #(
  parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  prc_in_if.sink                          in_ch,
  prc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [prc_pkg::CFG_W-1:0]       cfg_wdata
);
  import prc_pkg::*;

  localparam int CW = VERT_W + FRAC_BITS;
  localparam int OW = CW + 1;

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_TWO   = 2'd2;

  clip_cfg_t         clip_r;
  logic [CFG_W-1:0]  shift_x_r, shift_y_r;
  logic [1:0]        cnt_r;
  logic [OW-1:0]     pa_x_r, pa_y_r, pb_x_r, pb_y_r;

  logic              seg_valid, seg_ready;
  logic [CW-1:0]     seg_ax, seg_ay, seg_bx, seg_by;
  logic [OW-1:0]     sh_x, sh_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r    <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CLIP_LEFT:   clip_r.left   <= cfg_wdata;
        REG_CLIP_TOP:    clip_r.top    <= cfg_wdata;
        REG_CLIP_SPAN_X: clip_r.span_x <= cfg_wdata;
        REG_CLIP_SPAN_Y: clip_r.span_y <= cfg_wdata;
        REG_SHIFT_X:     shift_x_r     <= cfg_wdata;
        REG_SHIFT_Y:     shift_y_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  prc_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (clip_r),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg_ax    (seg_ax),
    .seg_ay    (seg_ay),
    .seg_bx    (seg_bx),
    .seg_by    (seg_by)
  );

  // sum of a point and a shifted offset always fits the output width
  assign sh_x      = {shift_x_r[CFG_W-1], shift_x_r, {FRAC_BITS{1'b0}}};
  assign sh_y      = {shift_y_r[CFG_W-1], shift_y_r, {FRAC_BITS{1'b0}}};
  assign seg_ready = (cnt_r == BUF_EMPTY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= BUF_EMPTY;
    end else if (seg_valid && seg_ready) begin
      cnt_r <= BUF_TWO;
    end else if (out_ch.valid && out_ch.ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      pa_x_r <= {seg_ax[CW-1], seg_ax} + sh_x;
      pa_y_r <= {seg_ay[CW-1], seg_ay} + sh_y;
      pb_x_r <= {seg_bx[CW-1], seg_bx} + sh_x;
      pb_y_r <= {seg_by[CW-1], seg_by} + sh_y;
    end
  end

  assign out_ch.valid        = (cnt_r != BUF_EMPTY);
  assign out_ch.point_x      = (cnt_r == BUF_TWO) ? pa_x_r : pb_x_r;
  assign out_ch.point_y      = (cnt_r == BUF_TWO) ? pa_y_r : pb_y_r;
  assign out_ch.segment_last = (cnt_r == BUF_ONE);

endmodule

FILE: rtl/prc_div.sv
// Two-lane restoring divider with shared divisor, rounds to nearest.
module prc_div #(
  parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  input  logic [prc_pkg::VERT_W+FRAC_BITS-1:0]              den,
  input  logic [2*(prc_pkg::VERT_W+FRAC_BITS)-1:0]          p_x,
  input  logic [2*(prc_pkg::VERT_W+FRAC_BITS)-1:0]          p_y,
  output logic                                              done,
  output logic [prc_pkg::VERT_W+FRAC_BITS-1:0]              q_x,
  output logic [prc_pkg::VERT_W+FRAC_BITS-1:0]              q_y
);
  import prc_pkg::*;

  localparam int MW   = VERT_W + FRAC_BITS;
  localparam int CNTW = $clog2(MW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [MW-1:0]   den_r;
  logic [MW-1:0]   rem_x_r, rem_y_r;
  logic [MW-1:0]   lo_x_r, lo_y_r;
  logic [MW:0]     t_x, t_y;
  logic            ge_x, ge_y;
  logic [MW:0]     s_x, s_y;
  logic            rnd_x, rnd_y;

  assign t_x  = {rem_x_r, lo_x_r[MW-1]};
  assign t_y  = {rem_y_r, lo_y_r[MW-1]};
  assign ge_x = t_x >= {1'b0, den_r};
  assign ge_y = t_y >= {1'b0, den_r};
  assign s_x  = t_x - {1'b0, den_r};
  assign s_y  = t_y - {1'b0, den_r};

  // remainder at least half the divisor rounds the quotient up
  assign rnd_x = {rem_x_r, 1'b0} >= {1'b0, den_r};
  assign rnd_y = {rem_y_r, 1'b0} >= {1'b0, den_r};
  assign q_x   = lo_x_r + MW'(rnd_x);
  assign q_y   = lo_y_r + MW'(rnd_y);
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r   <= den;
      rem_x_r <= p_x[2*MW-1:MW];
      rem_y_r <= p_y[2*MW-1:MW];
      lo_x_r  <= p_x[MW-1:0];
      lo_y_r  <= p_y[MW-1:0];
    end else if (busy_r) begin
      rem_x_r <= ge_x ? s_x[MW-1:0] : t_x[MW-1:0];
      rem_y_r <= ge_y ? s_y[MW-1:0] : t_y[MW-1:0];
      lo_x_r  <= {lo_x_r[MW-2:0], ge_x};
      lo_y_r  <= {lo_y_r[MW-2:0], ge_y};
    end
  end

endmodule

FILE: rtl/prc_seq.sv
// Segment sequencer: vertex intake, per-edge tests, multiply, divide and clip update.
module prc_seq #(
  parameter int FRAC_BITS = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  prc_in_if.sink                                     in_ch,
  input  prc_pkg::clip_cfg_t                         cfg,
  output logic                                       seg_valid,
  input  logic                                       seg_ready,
  output logic signed [prc_pkg::VERT_W+FRAC_BITS-1:0] seg_ax,
  output logic signed [prc_pkg::VERT_W+FRAC_BITS-1:0] seg_ay,
  output logic signed [prc_pkg::VERT_W+FRAC_BITS-1:0] seg_bx,
  output logic signed [prc_pkg::VERT_W+FRAC_BITS-1:0] seg_by
);
  import prc_pkg::*;

  localparam int CW = VERT_W + FRAC_BITS;
  localparam int MW = CW;
  localparam int EW = VERT_W + 2;
  localparam int DW = EW + FRAC_BITS + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIST = 7'b0000010,
    S_MULX = 7'b0000100,
    S_MULY = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_HAND = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  edge_t                edge_r;
  logic                 have_prev_r;
  logic [VERT_W-1:0]    prev_x_r, prev_y_r;
  logic                 start_r;
  logic [CW-1:0]        ax_r, ay_r, bx_r, by_r;
  logic                 move_b_r;
  logic [MW-1:0]        den_r, dmag_r;
  logic [2*MW-1:0]      px_r, py_r;
  logic                 negx_r, negy_r;

  logic                 in_acc;
  logic                 last_edge;
  logic [EW-1:0]        edge_px;
  logic [DW-1:0]        edge_fx;
  logic [CW-1:0]        ca, cb;
  logic [DW-1:0]        ca_e, cb_e;
  logic                 inward_neg;
  logic [DW-1:0]        d0, d1, d0_abs;
  logic                 d0_pos, d1_pos;
  logic                 drop, keep;
  logic [CW:0]          dab, dx, dy;
  logic [CW:0]          dab_abs, dx_abs, dy_abs;
  logic [MW-1:0]        mul_b;
  logic [2*MW-1:0]      prod;
  logic                 div_done;
  logic [MW-1:0]        q_x, q_y;
  logic [CW-1:0]        ix, iy;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign last_edge    = (edge_r == EDGE_BOTTOM);

  always_comb begin
    unique case (edge_r)
      EDGE_LEFT:   edge_px = {{2{cfg.left[CFG_W-1]}}, cfg.left};
      EDGE_RIGHT:  edge_px = {{2{cfg.left[CFG_W-1]}}, cfg.left} + {2'b00, cfg.span_x};
      EDGE_TOP:    edge_px = {{2{cfg.top[CFG_W-1]}}, cfg.top};
      EDGE_BOTTOM: edge_px = {{2{cfg.top[CFG_W-1]}}, cfg.top} + {2'b00, cfg.span_y};
      default:     edge_px = '0;
    endcase
  end

  assign edge_fx    = {edge_px[EW-1], edge_px, {FRAC_BITS{1'b0}}};
  assign ca         = (edge_r == EDGE_TOP || edge_r == EDGE_BOTTOM) ? ay_r : ax_r;
  assign cb         = (edge_r == EDGE_TOP || edge_r == EDGE_BOTTOM) ? by_r : bx_r;
  assign ca_e       = {{(DW-CW){ca[CW-1]}}, ca};
  assign cb_e       = {{(DW-CW){cb[CW-1]}}, cb};
  assign inward_neg = (edge_r == EDGE_RIGHT || edge_r == EDGE_BOTTOM);
  assign d0         = inward_neg ? (edge_fx - ca_e) : (ca_e - edge_fx);
  assign d1         = inward_neg ? (edge_fx - cb_e) : (cb_e - edge_fx);
  assign d0_pos     = !d0[DW-1] && (d0 != '0);
  assign d1_pos     = !d1[DW-1] && (d1 != '0);
  assign drop       = !d0_pos && !d1_pos;
  assign keep       = !d0[DW-1] && !d1[DW-1];
  assign d0_abs     = d0[DW-1] ? (-d0) : d0;

  assign dab     = {cb[CW-1], cb} - {ca[CW-1], ca};
  assign dab_abs = dab[CW] ? (-dab) : dab;
  assign dx      = {bx_r[CW-1], bx_r} - {ax_r[CW-1], ax_r};
  assign dx_abs  = dx[CW] ? (-dx) : dx;
  assign dy      = {by_r[CW-1], by_r} - {ay_r[CW-1], ay_r};
  assign dy_abs  = dy[CW] ? (-dy) : dy;

  assign mul_b = (state_r == S_MULX) ? dx_abs[MW-1:0] : dy_abs[MW-1:0];
  assign prod  = dmag_r * mul_b;

  prc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .den   (den_r),
    .p_x   (px_r),
    .p_y   (py_r),
    .done  (div_done),
    .q_x   (q_x),
    .q_y   (q_y)
  );

  assign ix = negx_r ? (ax_r - q_x) : (ax_r + q_x);
  assign iy = negy_r ? (ay_r - q_y) : (ay_r + q_y);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && !in_ch.line_start && have_prev_r) state_nxt = S_DIST;
      S_DIST: begin
        if (drop) state_nxt = S_IDLE;
        else if (keep) state_nxt = last_edge ? S_HAND : S_DIST;
        else state_nxt = S_MULX;
      end
      S_MULX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = last_edge ? S_HAND : S_DIST;
      S_HAND: if (seg_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      edge_r      <= EDGE_LEFT;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      start_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == S_MULY);
      if (in_acc) begin
        prev_x_r    <= in_ch.vert_x;
        prev_y_r    <= in_ch.vert_y;
        have_prev_r <= 1'b1;
        edge_r      <= EDGE_LEFT;
      end else if ((state_r == S_DIST && !drop && keep && !last_edge) ||
                   (state_r == S_DIV && div_done && !last_edge)) begin
        edge_r <= edge_t'(edge_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ax_r <= {prev_x_r, 1'b1, {(FRAC_BITS-1){1'b0}}};
          ay_r <= {prev_y_r, 1'b1, {(FRAC_BITS-1){1'b0}}};
          bx_r <= {in_ch.vert_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
          by_r <= {in_ch.vert_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
        end
      end
      S_DIST: begin
        move_b_r <= d0_pos;
        den_r    <= dab_abs[MW-1:0];
        dmag_r   <= d0_abs[MW-1:0];
      end
      S_MULX: begin
        px_r   <= prod;
        negx_r <= dx[CW];
      end
      S_MULY: begin
        py_r   <= prod;
        negy_r <= dy[CW];
      end
      S_DIV: begin
        if (div_done) begin
          if (move_b_r) begin
            bx_r <= ix;
            by_r <= iy;
          end else begin
            ax_r <= ix;
            ay_r <= iy;
          end
        end
      end
      default: ;
    endcase
  end

  assign seg_valid = (state_r == S_HAND);
  assign seg_ax    = ax_r;
  assign seg_ay    = ay_r;
  assign seg_bx    = bx_r;
  assign seg_by    = by_r;

endmodule

FILE: tb/tb_polyline_rect_clipper.sv
// Self-checking testbench for the polyline rectangle clipper.
`timescale 1ns / 1ps

module tb_polyline_rect_clipper;
  import prc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int OW = VERT_W + FRAC + 1;
  localparam int CLK_PERIOD = 4;
  localparam int IDLE_GAP = 4 * (FRAC + 20) + 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint OUT_MAX = (longint'(1) << (OW - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) << (OW - 1));

  typedef longint unsigned u64_t;

  typedef struct {
    logic [OW-1:0] px;
    logic [OW-1:0] py;
    logic          last;
  } point_t;

  class clip_scoreboard;
    longint clip_left, clip_top, span_x, span_y, shift_x, shift_y;
    longint prev_x, prev_y;
    bit have_prev;
    point_t pending_q[$];
    int errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_CLIP_LEFT:   clip_left = longint'($signed(val));
        REG_CLIP_TOP:    clip_top = longint'($signed(val));
        REG_CLIP_SPAN_X: span_x = longint'(val);
        REG_CLIP_SPAN_Y: span_y = longint'(val);
        REG_SHIFT_X:     shift_x = longint'($signed(val));
        REG_SHIFT_Y:     shift_y = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function u64_t mag(longint v);
      if (v < 0) return u64_t'(-v);
      return u64_t'(v);
    endfunction

    // inward signed distance of a point to one edge
    function longint edge_dist(edge_t e, longint x, longint y);
      case (e)
        EDGE_LEFT:  return x - clip_left * ONE;
        EDGE_RIGHT: return (clip_left + span_x) * ONE - x;
        EDGE_TOP:   return y - clip_top * ONE;
        default:    return (clip_top + span_y) * ONE - y;
      endcase
    endfunction

    // ca + (cb - ca) * d0 / (d0 - d1), round to nearest, ties away from zero
    function longint lerp_round(longint ca, longint cb, longint d0, longint d1);
      longint diff;
      u64_t den, p, q, r;
      diff = cb - ca;
      den = mag(d0 - d1);
      p = mag(d0) * mag(diff);
      q = p / den;
      r = p % den;
      if (r >= den - r) q++;
      return (diff < 0) ? ca - longint'(q) : ca + longint'(q);
    endfunction

    function logic [OW-1:0] place(longint v, longint shift);
      longint w;
      w = v + shift * ONE;
      if (w > OUT_MAX) w = OUT_MAX;
      if (w < OUT_MIN) w = OUT_MIN;
      return w[OW-1:0];
    endfunction

    function void note_vertex(logic signed [VERT_W-1:0] vx, logic signed [VERT_W-1:0] vy,
                              logic start);
      longint ax, ay, bx, by, d0, d1, ix, iy;
      point_t pt;
      if (start || !have_prev) begin
        prev_x = longint'(vx);
        prev_y = longint'(vy);
        have_prev = 1;
        return;
      end
      ax = prev_x * ONE + ONE / 2;
      ay = prev_y * ONE + ONE / 2;
      bx = longint'(vx) * ONE + ONE / 2;
      by = longint'(vy) * ONE + ONE / 2;
      prev_x = longint'(vx);
      prev_y = longint'(vy);
      for (int j = 0; j < 4; j++) begin
        d0 = edge_dist(edge_t'(j), ax, ay);
        d1 = edge_dist(edge_t'(j), bx, by);
        if (d0 <= 0 && d1 <= 0) return;
        if (!(d0 >= 0 && d1 >= 0)) begin
          ix = lerp_round(ax, bx, d0, d1);
          iy = lerp_round(ay, by, d0, d1);
          if (d0 > 0) begin
            bx = ix;
            by = iy;
          end else begin
            ax = ix;
            ay = iy;
          end
        end
      end
      pt.px = place(ax, shift_x);
      pt.py = place(ay, shift_y);
      pt.last = 1'b0;
      pending_q.insert(pending_q.size(), pt);
      pt.px = place(bx, shift_x);
      pt.py = place(by, shift_y);
      pt.last = 1'b1;
      pending_q.insert(pending_q.size(), pt);
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_point(logic [OW-1:0] px, logic [OW-1:0] py, logic last);
      point_t e;
      if (pending_q.size() == 0) begin
        fail($sformatf("unexpected point x=%0d y=%0d last=%0b", $signed(px), $signed(py), last));
        return;
      end
      e = pending_q.pop_front();
      if (e.px !== px || e.py !== py || e.last !== last)
        fail($sformatf("point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       $signed(e.px), $signed(e.py), e.last, $signed(px), $signed(py), last));
    endfunction

    function int waiting();
      return pending_q.size();
    endfunction

    function void close();
      if (pending_q.size() != 0)
        fail($sformatf("%0d expected points never arrived", pending_q.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  prc_in_if in_ch();
  prc_out_if #(.FRAC_BITS(FRAC)) out_ch();

  polyline_rect_clipper #(.FRAC_BITS(FRAC)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  clip_scoreboard sb;
  int in_gap_max = 16;
  int out_stall_max = 16;
  longint cur_left, cur_top, cur_span_x, cur_span_y;

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_point(out_ch.point_x, out_ch.point_y, out_ch.segment_last);
  end

  // result side back-pressure
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      n = $urandom_range(0, out_stall_max);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_idx <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(logic [CFG_W-1:0] l, logic [CFG_W-1:0] t, logic [CFG_W-1:0] sx,
                              logic [CFG_W-1:0] sy, logic [CFG_W-1:0] hx,
                              logic [CFG_W-1:0] hy);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_SPAN_X, sx);
    write_reg(REG_CLIP_SPAN_Y, sy);
    write_reg(REG_SHIFT_X, hx);
    write_reg(REG_SHIFT_Y, hy);
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    cfg_we <= 1'b0;
    cur_left = longint'($signed(l));
    cur_top = longint'($signed(t));
    cur_span_x = longint'(sx);
    cur_span_y = longint'(sy);
  endtask

  task automatic send_vertex(logic [VERT_W-1:0] x, logic [VERT_W-1:0] y, logic s);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vert_x <= x;
    in_ch.vert_y <= y;
    in_ch.line_start <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_vertex(x, y, s);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    hold_until_drained();
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // coordinate around one axis of the rectangle, clamped to the field range
  function automatic logic [VERT_W-1:0] near_coord(longint lo, longint span);
    longint margin, v;
    margin = span / 2 + 24;
    v = lo - margin + longint'($urandom_range(0, int'(span + 2 * margin)));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[VERT_W-1:0];
  endfunction

  task automatic run_random(int n_items);
    int sent, k;
    bit held;
    sent = 0;
    held = 0;
    while (sent < n_items) begin
      if (!held && sent >= n_items / 2) begin
        hold_until_drained();
        held = 1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_vertex(VERT_W'($urandom), VERT_W'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_vertex(near_coord(cur_left, cur_span_x), near_coord(cur_top, cur_span_y), 1'b1);
        sent++;
        k = $urandom_range(1, 8);
        repeat (k) begin
          send_vertex(near_coord(cur_left, cur_span_x), near_coord(cur_top, cur_span_y), 1'b0);
          sent++;
        end
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] small_signed(int range);
    return CFG_W'(int'($urandom_range(0, 2 * range)) - range);
  endfunction

  initial begin
    int n_items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.vert_x = '0;
    in_ch.vert_y = '0;
    in_ch.line_start = 1'b0;
    sb = new;
    cur_left = 0;
    cur_top = 0;
    cur_span_x = 0;
    cur_span_y = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: empty rectangle at origin; first vertex has no predecessor
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(16'sd6, 16'sd6, 1'b0);
    send_vertex(-16'sd1, -16'sd1, 1'b0);
    send_vertex(16'sd0, 16'sd0, 1'b1);
    send_vertex(-16'sd1, 16'sd0, 1'b0);

    quiesce();
    apply_config(-16'sd10, -16'sd20, 16'd100, 16'd60, 16'sd5, -16'sd3);
    send_vertex(16'sd0, 16'sd0, 1'b1);
    send_vertex(16'sd50, 16'sd10, 1'b0);
    send_vertex(-16'sd40, 16'sd10, 1'b0);
    send_vertex(16'sd120, 16'sd10, 1'b0);
    send_vertex(16'sd120, -16'sd50, 1'b1);
    send_vertex(16'sd120, 16'sd80, 1'b0);
    send_vertex(16'sd40, -16'sd60, 1'b1);
    send_vertex(16'sd40, 16'sd100, 1'b0);
    send_vertex(-16'sd100, -16'sd100, 1'b1);
    send_vertex(16'sd200, 16'sd150, 1'b0);
    send_vertex(16'h8000, 16'h8000, 1'b1);
    send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
    send_vertex(16'h7FFF, 16'h8000, 1'b0);
    send_vertex(16'h8000, 16'h7FFF, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd10, 16'sd10, 1'b0);
    send_vertex(16'sd200, 16'sd200, 1'b1);
    send_vertex(16'sd200, 16'sd200, 1'b0);
    send_vertex(16'sd89, 16'sd39, 1'b1);
    send_vertex(16'sd90, 16'sd40, 1'b0);

    for (int p = 1; p <= 7; p++) begin
      quiesce();
      n_items = 150;
      case (p)
        1: apply_config(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000);
        2: apply_config(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        3: begin
          apply_config(small_signed(300), small_signed(300), 16'd0,
                       CFG_W'($urandom_range(0, 600)), CFG_W'($urandom), CFG_W'($urandom));
          n_items = 40;
        end
        7: apply_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                        CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        default: apply_config(small_signed(300), small_signed(300),
                              CFG_W'($urandom_range(0, 600)), CFG_W'($urandom_range(0, 600)),
                              CFG_W'($urandom), CFG_W'($urandom));
      endcase
      in_gap_max = (p % 3 == 1) ? 0 : 16;
      out_stall_max = (p % 3 == 2) ? 0 : 16;
      run_random(n_items);
    end

    quiesce();
    sb.close();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: polyline_rect_clipper.f
rtl/prc_pkg.sv
rtl/prc_in_if.sv
rtl/prc_out_if.sv
rtl/prc_div.sv
rtl/prc_seq.sv
rtl/polyline_rect_clipper.sv
tb/tb_polyline_rect_clipper.sv
